[sv/spq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the stable priority queue
// Sizes of the store, action and error codes, channel payloads and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH     = 16;
	localparam int ID_BITS   = 16;
	localparam int PRIO_BITS = 3;
	localparam int CNT_BITS  = $clog2(DEPTH + 1);

	localparam logic [1:0] ACT_PUSH  = 2'd0;
	localparam logic [1:0] ACT_POP   = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_EMPTY = 2'd1;
	localparam logic [1:0] ERR_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]           action;
		logic [PRIO_BITS-1:0] priority_req;
		logic [ID_BITS-1:0]   client_id;
	} req_item_t;

	typedef struct packed {
		logic                 served_valid;
		logic [ID_BITS-1:0]   served_id;
		logic [PRIO_BITS-1:0] served_priority;
		logic                 is_empty;
		logic                 is_full;
		logic [1:0]           error_code;
	} rsp_item_t;

	typedef struct packed {
		logic load;
		logic exec;
	} spq_cmd_t;

	typedef struct packed {
		logic out_free;
	} spq_stat_t;

endpackage

`default_nettype wire

[sv/stable_priority_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded priority queue, FIFO within a class
// Push, pop, clear or no-op per item; one status result per item.
// ----------------------------------------------------------------------------
//  channel | signals                  | payload
//  req     | req_valid, req_stall     | action, priority_req, client_id
//  rsp     | rsp_valid, rsp_stall     | served_*, is_empty, is_full, error_code
//
//  An item is first taken in; then the cell row compares and shifts and
//  writes the result register.
//  A new item is taken while the previous result still waits on rsp.
//  rsp_stall holds the execute step until the result register frees up.
//  Reset empties the queue; entry contents are not cleared.
// ----------------------------------------------------------------------------
module stable_priority_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  spq_pkg::req_item_t  req,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output spq_pkg::rsp_item_t  rsp
);
	import spq_pkg::*;

	spq_cmd_t  cmd;
	spq_stat_t stat;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	spq_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("item taken while previous one still executing");

	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> rsp_valid)
		else $error("execute step left no result");

	a_empty_err: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.error_code == ERR_EMPTY) |-> (rsp.is_empty && !rsp.served_valid))
		else $error("pop error reported on a non-empty queue");

	a_full_err: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.error_code == ERR_FULL) |-> (rsp.is_full && !rsp.is_empty))
		else $error("push error reported on a queue that is not full");

endmodule

`default_nettype wire

[sv/spq_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ctrl: sequencer of the stable priority queue
// Takes one item, then fires the datapath once the result register is free.
// ----------------------------------------------------------------------------
module spq_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	output spq_pkg::spq_cmd_t   cmd,
	input  spq_pkg::spq_stat_t  stat
);
	import spq_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		cmd.load  = 1'b0;
		cmd.exec  = 1'b0;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// hold until the result register can take the outcome
				if (stat.out_free) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[sv/spq_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spq_datapath: sorted row of entry cells and result register
// Every cell compares its class with the pushed one in parallel; a push
// shifts the tail up by one, a pop shifts everything down by one.
// ----------------------------------------------------------------------------
module spq_datapath (
	input  wire                 clk,
	input  wire                 arst_n,
	input  spq_pkg::req_item_t  req,
	input  spq_pkg::spq_cmd_t   cmd,
	output spq_pkg::spq_stat_t  stat,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output spq_pkg::rsp_item_t  rsp
);
	import spq_pkg::*;

	req_item_t            item_q;
	logic [PRIO_BITS-1:0] prio_q [DEPTH];
	logic [ID_BITS-1:0]   id_q   [DEPTH];
	logic [PRIO_BITS-1:0] prio_d [DEPTH];
	logic [ID_BITS-1:0]   id_d   [DEPTH];
	logic [DEPTH-1:0]     le;
	logic [DEPTH-1:0]     ins;
	logic [CNT_BITS-1:0]  count_q;
	logic [CNT_BITS-1:0]  count_d;
	logic                 full;
	logic                 empty;
	logic                 do_push;
	logic                 do_pop;
	logic                 rsp_valid_q;
	rsp_item_t            rsp_q;
	rsp_item_t            rsp_d;

	assign full    = (count_q == CNT_BITS'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = cmd.exec && (item_q.action == ACT_PUSH) && !full;
	assign do_pop  = cmd.exec && (item_q.action == ACT_POP) && !empty;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		// stored entries at or ahead of the new class stay put
		assign le[i] = (CNT_BITS'(i) < count_q) && (prio_q[i] <= item_q.priority_req);

		if (i == 0) begin : g_head
			assign ins[i] = !le[i];
		end else begin : g_body
			assign ins[i] = !le[i] && le[i-1];
		end

		always_comb begin
			prio_d[i] = prio_q[i];
			id_d[i]   = id_q[i];
			if (do_push && !le[i]) begin
				if (ins[i]) begin
					prio_d[i] = item_q.priority_req;
					id_d[i]   = item_q.client_id;
				end else begin
					prio_d[i] = prio_q[(i > 0) ? i - 1 : 0];
					id_d[i]   = id_q[(i > 0) ? i - 1 : 0];
				end
			end else if (do_pop) begin
				prio_d[i] = prio_q[(i < DEPTH - 1) ? i + 1 : i];
				id_d[i]   = id_q[(i < DEPTH - 1) ? i + 1 : i];
			end
		end

		always_ff @(posedge clk) begin
			if (do_push || do_pop) begin
				prio_q[i] <= prio_d[i];
				id_q[i]   <= id_d[i];
			end
		end
	end

	always_comb begin
		count_d = count_q;
		rsp_d   = '0;
		case (item_q.action)
			ACT_PUSH: begin
				if (full) begin
					rsp_d.error_code = ERR_FULL;
				end else begin
					count_d = count_q + CNT_BITS'(1);
				end
			end
			ACT_POP: begin
				if (empty) begin
					rsp_d.error_code = ERR_EMPTY;
				end else begin
					count_d               = count_q - CNT_BITS'(1);
					rsp_d.served_valid    = 1'b1;
					rsp_d.served_id       = id_q[0];
					rsp_d.served_priority = prio_q[0];
				end
			end
			ACT_CLEAR: begin
				count_d = '0;
			end
			default: begin
				count_d = count_q;
			end
		endcase
		rsp_d.is_empty = (count_d == '0);
		rsp_d.is_full  = (count_d == CNT_BITS'(DEPTH));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q <= rsp_d;
		end
	end

	assign stat.out_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid     = rsp_valid_q;
	assign rsp           = rsp_q;

endmodule

`default_nettype wire

[test/stable_priority_queue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_tb: self-checking bench for the stable priority queue
// Sends push, pop, clear and no-op items with random gaps on the request side.
// Applies random stalls on the status side. Keeps a sorted copy of the store
// and checks every status item, field by field, in order of arrival.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;
	import spq_pkg::*;

	// the one action code the package leaves unnamed: no operation
	localparam logic [1:0] ACT_IDLE = 2'd3;
	localparam int RANDOM_ITEMS = 2000;
	localparam int QUIET_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 8;
	localparam int PRINT_CAP    = 100;

	class queue_scoreboard;
		logic [PRIO_BITS-1:0] slot_prio [DEPTH];
		logic [ID_BITS-1:0]   slot_id [DEPTH];
		int                   stored;
		rsp_item_t            awaited [$];
		int                   mismatches;
		int                   results_seen;
		int                   n_push, n_drop, n_served, n_empty_pop, n_clear, n_idle, n_full;

		function new();
			stored       = 0;
			mismatches   = 0;
			results_seen = 0;
			n_push       = 0;
			n_drop       = 0;
			n_served     = 0;
			n_empty_pop  = 0;
			n_clear      = 0;
			n_idle       = 0;
			n_full       = 0;
		endfunction

		// Work out the status item that one accepted request must produce.
		function void note_request(req_item_t it);
			rsp_item_t want;
			int        pos;
			int        k;
			want = '0;
			case (it.action)
			ACT_PUSH: begin
				if (stored == DEPTH) begin
					want.error_code = ERR_FULL;
					n_drop++;
				end else begin
					// insert behind every entry of the same or better class
					pos = 0;
					while (pos < stored && slot_prio[pos] <= it.priority_req)
						pos++;
					for (k = stored; k > pos; k--) begin
						slot_prio[k] = slot_prio[k-1];
						slot_id[k]   = slot_id[k-1];
					end
					slot_prio[pos] = it.priority_req;
					slot_id[pos]   = it.client_id;
					stored++;
					n_push++;
				end
			end
			ACT_POP: begin
				if (stored == 0) begin
					want.error_code = ERR_EMPTY;
					n_empty_pop++;
				end else begin
					want.served_valid    = 1'b1;
					want.served_id       = slot_id[0];
					want.served_priority = slot_prio[0];
					for (k = 1; k < stored; k++) begin
						slot_prio[k-1] = slot_prio[k];
						slot_id[k-1]   = slot_id[k];
					end
					stored--;
					n_served++;
				end
			end
			ACT_CLEAR: begin
				stored = 0;
				n_clear++;
			end
			ACT_IDLE: begin
				n_idle++;
			end
			endcase
			want.is_empty = (stored == 0);
			want.is_full  = (stored == DEPTH);
			if (want.is_full)
				n_full++;
			awaited.push_back(want);
		endfunction

		task report_mismatch(string msg);
			if (mismatches < PRINT_CAP)
				$display("[%0t] status item %0d: %s", $time, results_seen, msg);
			mismatches++;
		endtask

		task check_result(rsp_item_t got);
			rsp_item_t want;
			results_seen++;
			if (awaited.size() == 0) begin
				report_mismatch("arrived with nothing expected");
				return;
			end
			want = awaited.pop_front();
			if (got.served_valid !== want.served_valid)
				report_mismatch($sformatf("served_valid got %0b want %0b",
					got.served_valid, want.served_valid));
			if (got.served_id !== want.served_id)
				report_mismatch($sformatf("served_id got %h want %h",
					got.served_id, want.served_id));
			if (got.served_priority !== want.served_priority)
				report_mismatch($sformatf("served_priority got %0d want %0d",
					got.served_priority, want.served_priority));
			if (got.is_empty !== want.is_empty)
				report_mismatch($sformatf("is_empty got %0b want %0b",
					got.is_empty, want.is_empty));
			if (got.is_full !== want.is_full)
				report_mismatch($sformatf("is_full got %0b want %0b",
					got.is_full, want.is_full));
			if (got.error_code !== want.error_code)
				report_mismatch($sformatf("error_code got %0d want %0d",
					got.error_code, want.error_code));
		endtask
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_item_t rsp;

	logic      calm;
	int        quiet;
	int        items_sent;

	queue_scoreboard sb = new();

	stable_priority_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one; none during a calm stretch.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic req_item_t make_item(int push_pct, int pop_pct, int prio_top);
		req_item_t it;
		int        r;
		it.priority_req = PRIO_BITS'($urandom_range(0, prio_top));
		it.client_id    = ID_BITS'($urandom);
		r = $urandom_range(0, 99);
		if (r < push_pct)
			it.action = ACT_PUSH;
		else if (r < push_pct + pop_pct)
			it.action = ACT_POP;
		else if (r[0])
			it.action = ACT_CLEAR;
		else
			it.action = ACT_IDLE;
		return it;
	endfunction

	// Called at a rising edge; returns at the edge that accepts the item.
	task automatic send_item(req_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			req       <= $bits(req_item_t)'($urandom);
			repeat (gap) @(posedge clk);
		end
		req       <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_fields(logic [1:0] act, int prio, int id);
		req_item_t it;
		it.action       = act;
		it.priority_req = PRIO_BITS'(prio);
		it.client_id    = ID_BITS'(id);
		send_item(it);
	endtask

	// Status side: random stall runs between short free runs.
	initial begin
		int n;
		rsp_stall <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			n = pick_gap();
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	// Sample both channels at the edge; a watchdog ends a stuck run.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				sb.note_request(req);
			if (rsp_valid && !rsp_stall)
				sb.check_result(rsp);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("[%0t] no handshake for %0d cycles, %0d status items outstanding",
					$time, QUIET_LIMIT, sb.awaited.size());
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		int i;
		int n;
		int kind;
		int len;
		int top;
		int push_pct;
		int pop_pct;
		calm       = 1'b0;
		quiet      = 0;
		items_sent = 0;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store: pop, clear and no-op
		send_fields(ACT_POP, 5, 16'h1111);
		send_fields(ACT_CLEAR, 7, 16'hffff);
		send_fields(ACT_IDLE, 3, 16'h5a5a);
		// field extremes
		send_fields(ACT_PUSH, 7, 16'hffff);
		send_fields(ACT_PUSH, 0, 16'h0000);
		send_fields(ACT_PUSH, 3, 16'ha5a5);
		// fill to the top with repeated classes, then push once more to drop
		for (i = 0; i < DEPTH - 3; i++)
			send_fields(ACT_PUSH, (i * 5) % 8, 16'h0100 + i);
		send_fields(ACT_PUSH, 0, 16'hdead);
		send_fields(ACT_IDLE, 0, 16'h0000);
		send_fields(ACT_POP, 0, 16'h0000);
		send_fields(ACT_POP, 7, 16'hffff);
		send_fields(ACT_CLEAR, 0, 16'h0000);

		// bursts of well-formed traffic with random content, some noise
		n = 0;
		while (n < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			len  = $urandom_range(4, 40);
			case ($urandom_range(0, 3))
			0: top = 0;
			1: top = 1;
			default: top = 7;
			endcase
			if (kind < 3) begin
				push_pct = 80;
				pop_pct  = 18;
			end else if (kind < 5) begin
				push_pct = 15;
				pop_pct  = 83;
			end else if (kind < 8) begin
				push_pct = 50;
				pop_pct  = 47;
			end else if (kind == 8) begin
				push_pct = 30;
				pop_pct  = 30;
			end else begin
				push_pct = 96;
				pop_pct  = 4;
			end
			calm = ($urandom_range(0, 5) == 0);
			for (i = 0; i < len && n < RANDOM_ITEMS; i++) begin
				send_item(make_item(push_pct, pop_pct, top));
				n++;
			end
		end
		req_valid <= 1'b0;
		calm = 1'b0;

		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d items: %0d pushes stored, %0d dropped at full, %0d clears, %0d no-ops",
			items_sent, sb.n_push, sb.n_drop, sb.n_clear, sb.n_idle);
		$display("Pops: %0d served, %0d on empty; store full after %0d items",
			sb.n_served, sb.n_empty_pop, sb.n_full);
		if (sb.mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
